// ===== hdl/lfutc_pkg.sv =====
// ----------------------------------------------------------------------------
// LFU tag cache package
// Widths, register indexes, reset values and the register bundle shared by
// the tag cache policy modules.
// ----------------------------------------------------------------------------
package lfutc_pkg;

	// Use counter and configuration widths
	localparam int CNT_W      = 15;
	localparam int CFG_IDX_W  = 2;
	localparam int KEY_IN_W   = 16;
	localparam int SLOT_OUT_W = 8;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_COUNT_LIMIT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT_RESTART = 2'd1;

	// Register reset values
	localparam logic [CNT_W-1:0] LIMIT_RESET   = 15'd30000;
	localparam logic [CNT_W-1:0] RESTART_RESET = 15'd10000;

	// Register values as seen by the scan sequencer
	typedef struct packed {
		logic [CNT_W-1:0] count_limit;
		logic [CNT_W-1:0] count_restart;
	} cfg_regs_t;

endpackage

// ===== hdl/lfutc_if.sv =====
// ----------------------------------------------------------------------------
// LFU tag cache channel interfaces
// Valid/ready channels for requests, responses and register writes.
// ----------------------------------------------------------------------------

// Request channel: one lookup item
interface lfutc_req_if import lfutc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                mode;
	logic                key_present;
	logic [KEY_IN_W-1:0] key;

	modport source (output valid, mode, key_present, key, input ready);
	modport sink   (input valid, mode, key_present, key, output ready);
endinterface

// Response channel: one result item per request
interface lfutc_rsp_if import lfutc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  hit;
	logic                  filled;
	logic [SLOT_OUT_W-1:0] slot;

	modport source (output valid, hit, filled, slot, input ready);
	modport sink   (input valid, hit, filled, slot, output ready);
endinterface

// Register write channel
interface lfutc_cfg_if import lfutc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CNT_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/lfutc_cfg.sv =====
// ----------------------------------------------------------------------------
// LFU tag cache configuration registers
// Decodes register writes into the count limit and restart value.
// ----------------------------------------------------------------------------
module lfutc_cfg import lfutc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	lfutc_cfg_if.sink   cfg,
	output cfg_regs_t   regs
);

	cfg_regs_t regs_q;

	// Writes are always taken
	assign cfg.ready = 1'b1;

	// Register file; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.count_limit   <= LIMIT_RESET;
			regs_q.count_restart <= RESTART_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_COUNT_LIMIT:   regs_q.count_limit   <= cfg.data;
				REG_COUNT_RESTART: regs_q.count_restart <= cfg.data;
				default: ;
			endcase
		end
	end

	assign regs = regs_q;

endmodule

// ===== hdl/lfu_tag_cache_policy_top.sv =====
// ----------------------------------------------------------------------------
// LFU tag cache policy
// Fully associative tag cache with per-slot use counters and least
// frequently used replacement, scanned one slot per cycle.
// ----------------------------------------------------------------------------
//  channel | dir | payload                        | accepted when
//  --------+-----+--------------------------------+----------------------
//  req     | in  | mode, key_present, key         | req.valid & req.ready
//  rsp     | out | hit, filled, slot              | rsp.valid & rsp.ready
//  cfg     | in  | index, data                    | cfg.valid & cfg.ready
//
//  A keyed miss runs from accept to next accept through the idle state, one
//  memory read per slot, the registered read data and the result load. A hit
//  ends the scan at its slot; a null request goes from the idle state straight
//  to the result load. req.ready is low while a scan runs; a result waiting in
//  the output register holds the sequencer only once the next result is due.
//  Reset clears the valid bits at once, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module lfu_tag_cache_policy_top import lfutc_pkg::*; #(
	parameter int SLOTS    = 50,
	parameter int KEY_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	lfutc_req_if.sink   req,
	lfutc_rsp_if.source rsp,
	lfutc_cfg_if.sink   cfg
);

	localparam int IW    = $clog2(SLOTS);
	localparam int MEM_W = KEY_BITS + CNT_W;

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_RESULT} state_t;

	cfg_regs_t regs;

	state_t              state_q;
	logic [IW-1:0]       rd_idx_q;
	logic                rd_busy_q;
	logic                cmp_vld_q;
	logic [IW-1:0]       cmp_idx_q;
	logic [MEM_W-1:0]    mem_rdata_q;
	logic [SLOTS-1:0]    valid_q;
	logic [CNT_W-1:0]    run_min_q;
	logic [IW-1:0]       victim_q;
	logic                have_victim_q;
	logic                mode_q;
	logic [KEY_BITS-1:0] key_q;
	logic                res_hit_q;
	logic                res_fill_q;
	logic [IW-1:0]       res_slot_q;
	logic                out_vld_q;
	logic                out_hit_q;
	logic                out_fill_q;
	logic [IW-1:0]       out_slot_q;

	logic [MEM_W-1:0]    mem [SLOTS];

	logic                cur_valid;
	logic [KEY_BITS-1:0] cur_key;
	logic [CNT_W-1:0]    cur_cnt;
	logic [CNT_W:0]      cnt_inc;
	logic [CNT_W-1:0]    hit_cnt;
	logic                is_hit;
	logic                is_lower;
	logic                is_last;
	logic [CNT_W-1:0]    min_nxt;
	logic [IW-1:0]       victim_nxt;
	logic                have_nxt;
	logic                fill_go;
	logic                mem_we;
	logic [IW-1:0]       mem_waddr;
	logic [MEM_W-1:0]    mem_wdata;
	logic [31:0]         key_ext;

	// Register file
	lfutc_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	assign key_ext = {16'b0, req.key};

	// Slot under compare; an invalid slot counts as zero
	assign cur_valid = valid_q[cmp_idx_q];
	assign cur_key   = mem_rdata_q[CNT_W +: KEY_BITS];
	assign cur_cnt   = cur_valid ? mem_rdata_q[CNT_W-1:0] : '0;
	assign is_hit    = cmp_vld_q && cur_valid && (cur_key == key_q);
	assign is_last   = (cmp_idx_q == IW'(SLOTS - 1));

	// Hit counter update, pulled back at the limit
	assign cnt_inc = {1'b0, cur_cnt} + (CNT_W+1)'(1);
	assign hit_cnt = (cnt_inc >= {1'b0, regs.count_limit}) ?
		regs.count_restart : cnt_inc[CNT_W-1:0];

	// Running minimum; lowest index wins ties
	assign is_lower   = cmp_vld_q && (cur_cnt < run_min_q);
	assign min_nxt    = is_lower ? cur_cnt : run_min_q;
	assign victim_nxt = is_lower ? cmp_idx_q : victim_q;
	assign have_nxt   = is_lower || have_victim_q;

	assign fill_go = cmp_vld_q && !is_hit && is_last && !mode_q && have_nxt;

	// Single memory write port: hit count update or victim fill
	assign mem_we    = (state_q == ST_SCAN) && (is_hit || fill_go);
	assign mem_waddr = is_hit ? cmp_idx_q : victim_nxt;
	assign mem_wdata = is_hit ? {cur_key, hit_cnt} : {key_q, CNT_W'(1)};

	// Key and count memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		mem_rdata_q <= mem[rd_idx_q];
	end

	// Scan sequencer and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			rd_idx_q      <= '0;
			rd_busy_q     <= 1'b0;
			cmp_vld_q     <= 1'b0;
			cmp_idx_q     <= '0;
			valid_q       <= '0;
			run_min_q     <= '0;
			victim_q      <= '0;
			have_victim_q <= 1'b0;
			mode_q        <= 1'b0;
			key_q         <= '0;
			res_hit_q     <= 1'b0;
			res_fill_q    <= 1'b0;
			res_slot_q    <= '0;
			out_vld_q     <= 1'b0;
			out_hit_q     <= 1'b0;
			out_fill_q    <= 1'b0;
			out_slot_q    <= '0;
		end else begin
			if (out_vld_q && rsp.ready) begin
				out_vld_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						mode_q        <= req.mode;
						key_q         <= key_ext[KEY_BITS-1:0];
						run_min_q     <= regs.count_limit;
						have_victim_q <= 1'b0;
						victim_q      <= '0;
						rd_idx_q      <= '0;
						cmp_vld_q     <= 1'b0;
						res_hit_q     <= 1'b0;
						res_fill_q    <= 1'b0;
						res_slot_q    <= '0;
						if (req.key_present) begin
							rd_busy_q <= 1'b1;
							state_q   <= ST_SCAN;
						end else begin
							state_q   <= ST_RESULT;
						end
					end
				end

				ST_SCAN: begin
					// Read side: one slot per cycle
					cmp_vld_q <= rd_busy_q;
					cmp_idx_q <= rd_idx_q;
					if (rd_busy_q) begin
						if (rd_idx_q == IW'(SLOTS - 1)) begin
							rd_busy_q <= 1'b0;
						end else begin
							rd_idx_q <= rd_idx_q + IW'(1);
						end
					end
					// Compare side
					run_min_q     <= min_nxt;
					victim_q      <= victim_nxt;
					have_victim_q <= have_nxt;
					if (is_hit) begin
						res_hit_q  <= 1'b1;
						res_slot_q <= cmp_idx_q;
						rd_busy_q  <= 1'b0;
						cmp_vld_q  <= 1'b0;
						state_q    <= ST_RESULT;
					end else if (cmp_vld_q && is_last) begin
						if (fill_go) begin
							res_fill_q          <= 1'b1;
							res_slot_q          <= victim_nxt;
							valid_q[victim_nxt] <= 1'b1;
						end
						cmp_vld_q <= 1'b0;
						state_q   <= ST_RESULT;
					end
				end

				ST_RESULT: begin
					if (!out_vld_q || rsp.ready) begin
						out_vld_q  <= 1'b1;
						out_hit_q  <= res_hit_q;
						out_fill_q <= res_fill_q;
						out_slot_q <= res_slot_q;
						state_q    <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign req.ready  = (state_q == ST_IDLE);
	assign rsp.valid  = out_vld_q;
	assign rsp.hit    = out_hit_q;
	assign rsp.filled = out_fill_q;
	assign rsp.slot   = SLOT_OUT_W'(out_slot_q);

endmodule

// ===== hdl/lfutc_checker.sv =====
// ----------------------------------------------------------------------------
// LFU tag cache port checker
// Port-level properties of the tag cache, bound to the top level.
// ----------------------------------------------------------------------------
module lfutc_checker import lfutc_pkg::*; #(
	parameter int SLOTS = 50
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  req_valid,
	input logic                  req_ready,
	input logic                  rsp_valid,
	input logic                  rsp_ready,
	input logic                  rsp_hit,
	input logic                  rsp_filled,
	input logic [SLOT_OUT_W-1:0] rsp_slot
);

	// An item is either a hit or a fill, never both
	a_hit_xor_fill: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp_hit && rsp_filled))
		else $error("response reports both hit and fill");

	// Neither hit nor fill reports slot zero
	a_idle_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_hit && !rsp_filled) |-> (rsp_slot == '0))
		else $error("slot nonzero without hit or fill");

	// Reported slot lies within the table
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (int'(rsp_slot) < SLOTS))
		else $error("slot beyond table");

	// Block is busy right after taking a request
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request taken while previous one in flight");

	// A stalled response holds its item
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=>
			(rsp_valid && $stable(rsp_hit) && $stable(rsp_filled) && $stable(rsp_slot)))
		else $error("stalled response changed");

endmodule

bind lfu_tag_cache_policy_top lfutc_checker #(
	.SLOTS (SLOTS)
) u_lfutc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_hit    (rsp.hit),
	.rsp_filled (rsp.filled),
	.rsp_slot   (rsp.slot)
);

// ===== tb/lfu_tag_cache_policy_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LFU tag cache policy testbench
// Drives lookup items into the tag cache through a queue-fed driver and checks
// every response against an in-bench LFU predictor. Register settings change
// between phases while the cache is drained: reset values, a small limit, the
// largest limit, a restart at or above the limit and a zero limit. Both
// channel sides idle in random bursts, and the response side holds off once
// for a long stretch so that the cache backs up into its request channel.
// ----------------------------------------------------------------------------
module lfu_tag_cache_policy_top_tb;
	import lfutc_pkg::*;

	localparam int SLOTS       = 50;
	localparam int KEY_BITS    = 16;
	localparam int CYCLE_LIMIT = 500000;
	localparam int DRAIN_WAIT  = 60;
	localparam int PRESSURE_AT = 150;
	localparam int PRESSURE_LEN = 400;
	localparam logic [KEY_IN_W-1:0] KEY_MASK = KEY_IN_W'((64'd1 << KEY_BITS) - 1);

	// One lookup item and one response item
	typedef struct packed {
		logic                mode;
		logic                key_present;
		logic [KEY_IN_W-1:0] key;
	} lookup_req_t;

	typedef struct packed {
		logic                  hit;
		logic                  filled;
		logic [SLOT_OUT_W-1:0] slot;
	} lookup_rsp_t;

	logic clk = 1'b0;
	logic arst_n;

	lfutc_req_if req_if ();
	lfutc_rsp_if rsp_if ();
	lfutc_cfg_if cfg_if ();

	lfu_tag_cache_policy_top #(
		.SLOTS    (SLOTS),
		.KEY_BITS (KEY_BITS)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if),
		.cfg    (cfg_if)
	);

	always #5 clk = ~clk;

	// Predictor copy of the cache contents and registers
	logic [KEY_BITS-1:0] tag_key   [SLOTS];
	bit                  tag_valid [SLOTS];
	logic [CNT_W-1:0]    tag_count [SLOTS];
	cfg_regs_t           pol_cfg;

	lookup_req_t pending_reqs[$];
	lookup_rsp_t expected_results[$];

	bit quiet = 1'b0;
	int errors = 0;
	int hits_seen = 0;
	int fills_seen = 0;
	int empty_seen = 0;
	int results_seen = 0;
	int cycles = 0;

	// Expected response for one item; updates the predictor state
	function automatic lookup_rsp_t lfu_predict(input lookup_req_t r);
		lookup_rsp_t       res;
		logic [KEY_BITS-1:0] k;
		logic [CNT_W:0]    c;
		logic [CNT_W-1:0]  run_min;
		bit                found;
		int                victim;
		res     = '0;
		k       = KEY_BITS'(r.key & KEY_MASK);
		run_min = pol_cfg.count_limit;
		found   = 1'b0;
		victim  = 0;
		if (!r.key_present)
			return res;
		for (int i = 0; i < SLOTS; i++) begin
			if (tag_valid[i] && tag_key[i] == k) begin
				c = {1'b0, tag_count[i]} + 1'b1;
				if (c >= {1'b0, pol_cfg.count_limit})
					c = {1'b0, pol_cfg.count_restart};
				tag_count[i] = c[CNT_W-1:0];
				res.hit  = 1'b1;
				res.slot = SLOT_OUT_W'(i);
				return res;
			end
			if (tag_count[i] < run_min) begin
				run_min = tag_count[i];
				victim  = i;
				found   = 1'b1;
			end
		end
		// lookup-only miss, or no counter below the limit
		if (r.mode || !found)
			return res;
		tag_key[victim]   = k;
		tag_valid[victim] = 1'b1;
		tag_count[victim] = CNT_W'(1);
		res.filled = 1'b1;
		res.slot   = SLOT_OUT_W'(victim);
		return res;
	endfunction

	// Request driver: presents the head of the pending queue
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		bit took;
		if (!arst_n) begin
			req_if.valid       <= 1'b0;
			req_if.mode        <= 1'b0;
			req_if.key_present <= 1'b0;
			req_if.key         <= '0;
			gap_left = 0;
		end else begin
			took = req_if.valid && req_if.ready;
			if (took)
				expected_results.push_back(lfu_predict(pending_reqs.pop_front()));
			if (req_if.valid && !took) begin
				// hold the offered item
			end else if (gap_left > 0) begin
				gap_left--;
				req_if.valid <= 1'b0;
			end else if (pending_reqs.size() != 0 && !quiet && $urandom_range(0, 1) == 0) begin
				gap_left = $urandom_range(1, 13) - 1;
				req_if.valid <= 1'b0;
			end else if (pending_reqs.size() != 0) begin
				req_if.valid       <= 1'b1;
				req_if.mode        <= pending_reqs[0].mode;
				req_if.key_present <= pending_reqs[0].key_present;
				req_if.key         <= pending_reqs[0].key;
			end else begin
				req_if.valid <= 1'b0;
			end
		end
	end

	// Response monitor: random stalls, one long hold-off, field checks
	int  stall_left = 0;
	int  hold_left = 0;
	bit  pressure_done = 1'b0;
	always @(posedge clk or negedge arst_n) begin
		lookup_rsp_t exp_rsp;
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
		end else begin
			if (rsp_if.valid && rsp_if.ready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					$error("response with no item outstanding: hit %0d filled %0d slot %0d",
						rsp_if.hit, rsp_if.filled, rsp_if.slot);
					errors++;
				end else begin
					exp_rsp = expected_results.pop_front();
					if (rsp_if.hit !== exp_rsp.hit) begin
						$error("hit: expected %0d, got %0d", exp_rsp.hit, rsp_if.hit);
						errors++;
					end
					if (rsp_if.filled !== exp_rsp.filled) begin
						$error("filled: expected %0d, got %0d", exp_rsp.filled, rsp_if.filled);
						errors++;
					end
					if (rsp_if.slot !== exp_rsp.slot) begin
						$error("slot: expected %0d, got %0d", exp_rsp.slot, rsp_if.slot);
						errors++;
					end
					if (exp_rsp.hit)
						hits_seen++;
					else if (exp_rsp.filled)
						fills_seen++;
					else
						empty_seen++;
				end
			end
			if (!pressure_done && results_seen >= PRESSURE_AT) begin
				pressure_done = 1'b1;
				hold_left = PRESSURE_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_if.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_if.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 13) - 1;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end
	end

	// Run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("lfu_tag_cache_policy_top_tb: errors");
			$finish;
		end
	end

	task automatic push_req(input logic mode, input logic present, input logic [15:0] key);
		lookup_req_t r;
		r.mode        = mode;
		r.key_present = present;
		r.key         = key;
		pending_reqs.push_back(r);
	endtask

	task automatic drain();
		while (pending_reqs.size() != 0 || expected_results.size() != 0)
			@(posedge clk);
	endtask

	// Register write; the predictor follows at the accepting edge
	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
		@(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= val;
		do @(posedge clk); while (!cfg_if.ready);
		if (idx == REG_COUNT_LIMIT)
			pol_cfg.count_limit = val;
		else if (idx == REG_COUNT_RESTART)
			pol_cfg.count_restart = val;
		cfg_if.valid <= 1'b0;
	endtask

	// Random lookups over a small key pool so that hits and evictions mix
	task automatic run_lookups(input int n, input int pool_n, input int alloc_pct);
		logic [15:0] pool[$];
		lookup_req_t r;
		for (int i = 0; i < pool_n; i++)
			pool.push_back(16'($urandom_range(0, 65535)));
		for (int i = 0; i < n; i++) begin
			r.key_present = ($urandom_range(0, 9) != 0);
			r.mode        = ($urandom_range(0, 99) >= alloc_pct);
			if ($urandom_range(0, 6) == 0)
				r.key = 16'($urandom_range(0, 65535));
			else
				r.key = pool[$urandom_range(0, pool_n - 1)];
			pending_reqs.push_back(r);
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		req_if.valid       = 1'b0;
		req_if.mode        = 1'b0;
		req_if.key_present = 1'b0;
		req_if.key         = '0;
		rsp_if.ready       = 1'b0;
		cfg_if.valid       = 1'b0;
		cfg_if.index       = REG_COUNT_LIMIT;
		cfg_if.data        = '0;
		pol_cfg.count_limit   = LIMIT_RESET;
		pol_cfg.count_restart = RESTART_RESET;
		for (int i = 0; i < SLOTS; i++) begin
			tag_key[i]   = '0;
			tag_valid[i] = 1'b0;
			tag_count[i] = '0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: null requests, misses in both modes, fills, hits
		push_req(1'b0, 1'b0, 16'h0000);
		push_req(1'b1, 1'b0, 16'hFFFF);
		push_req(1'b1, 1'b1, 16'hFFFF);
		push_req(1'b0, 1'b1, 16'h0000);
		push_req(1'b0, 1'b1, 16'hFFFF);
		push_req(1'b0, 1'b1, 16'h0000);
		push_req(1'b1, 1'b1, 16'hFFFF);
		push_req(1'b1, 1'b1, 16'h5A5A);
		push_req(1'b0, 1'b1, 16'hA5A5);
		push_req(1'b0, 1'b1, 16'h8001);
		push_req(1'b1, 1'b1, 16'hA5A5);
		push_req(1'b0, 1'b0, 16'hA5A5);
		push_req(1'b0, 1'b1, 16'h5A5A);
		push_req(1'b0, 1'b1, 16'h8001);
		push_req(1'b0, 1'b1, 16'h0001);
		push_req(1'b1, 1'b1, 16'h0001);
		push_req(1'b0, 1'b1, 16'h7FFF);
		push_req(1'b0, 1'b1, 16'hFFFF);
		push_req(1'b1, 1'b1, 16'h1234);
		push_req(1'b0, 1'b1, 16'h1234);
		drain();

		// Reset register values
		run_lookups(260, 64, 80);

		// Small limit, restart above it: counters stick and victims run out
		set_reg(REG_COUNT_LIMIT, 15'd2);
		set_reg(REG_COUNT_RESTART, 15'd32766);
		run_lookups(220, 60, 85);

		// Zero limit: no victim ever, every hit restarts; unused indexes ignored
		set_reg(REG_COUNT_LIMIT, 15'd0);
		set_reg(REG_COUNT_RESTART, 15'd0);
		set_reg(2'd2, 15'h7FFF);
		set_reg(2'd3, 15'h5555);
		run_lookups(40, 60, 80);

		// Largest limit with restart just below it
		set_reg(REG_COUNT_LIMIT, 15'h7FFF);
		set_reg(REG_COUNT_RESTART, 15'd32766);
		run_lookups(150, 70, 80);

		// Small limit with a tight key pool so counters climb to it
		set_reg(REG_COUNT_LIMIT, 15'd100);
		set_reg(REG_COUNT_RESTART, 15'd1);
		run_lookups(220, 8, 75);

		// Back to reset values, no idling on either side
		set_reg(REG_COUNT_LIMIT, LIMIT_RESET);
		set_reg(REG_COUNT_RESTART, RESTART_RESET);
		quiet <= 1'b1;
		run_lookups(150, 64, 80);

		repeat (DRAIN_WAIT) @(posedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d responses never arrived", expected_results.size());
			errors++;
		end
		$display("covered %0d responses: %0d hits, %0d fills, %0d with no slot",
			results_seen, hits_seen, fills_seen, empty_seen);
		$display("over six register settings, including zero and full-scale limits");
		if (errors == 0)
			$display("lfu_tag_cache_policy_top_tb: clean");
		else
			$display("lfu_tag_cache_policy_top_tb: errors");
		$finish;
	end

endmodule
